// ----- hw/rtl/gtd_pkg.sv -----
`timescale 1ns / 1ps

package gtd_pkg;

  // Field and register widths.
  localparam int NUM_W   = 20;
  localparam int OFS_W   = 10;
  localparam int STEP_W  = 12;
  localparam int VAL_W   = 16;
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NUM_W;

  localparam int FRAME_BITS = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIPER_OFS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OHMS_STEP = 2'd2;

  // Register reset values.
  localparam logic [NUM_W-1:0]  GAIN_NUM_RST  = 20'd494000;
  localparam logic [OFS_W-1:0]  WIPER_OFS_RST = 10'd52;
  localparam logic [STEP_W-1:0] OHMS_STEP_RST = 12'd391;

  // Request decode and code limits.
  localparam logic FUNC_GAIN = 1'b0;
  localparam logic FUNC_RAW  = 1'b1;
  localparam logic [VAL_W-1:0]  GAIN_UNITY = 16'd10;
  localparam logic [CODE_W-1:0] CODE_MAX   = 8'd255;
  localparam logic [CODE_W-1:0] CODE_MIN   = 8'd1;
  localparam logic [CODE_W-1:0] CMD_WRITE  = 8'h11;

  // Status of the shared divider as seen by the front end.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Status of the code queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hw/rtl/gtd_div.sv -----
`timescale 1ns / 1ps

module gtd_div
  import gtd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [VAL_W-1:0] dvs_r;
  logic [VAL_W:0]   rem_sh, rem_diff;
  logic             ge;

  // One restoring step per cycle; a zero divisor yields all ones.
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_nxt  = ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/gtd_front.sv -----
`timescale 1ns / 1ps

module gtd_front
  import gtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_func,
  input  logic [VAL_W-1:0]  in_value,
  input  logic [NUM_W-1:0]  gain_num,
  input  logic [OFS_W-1:0]  wiper_ofs,
  input  logic [STEP_W-1:0] ohms_step,
  input  q_stat_t           q_stat,
  output logic              q_push,
  output logic [CODE_W-1:0] q_code
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_R,
    ST_DIV_C,
    ST_DONE
  } state_t;

  state_t            st_r;
  logic [CODE_W-1:0] code_r;

  logic              accept;
  logic              div_start;
  logic [NUM_W-1:0]  div_dvd;
  logic [VAL_W-1:0]  div_dvs;
  logic [NUM_W-1:0]  div_quo;
  div_stat_t         div_st;
  logic              below_ofs;
  logic [NUM_W-1:0]  ofs_ext;

  assign ofs_ext   = NUM_W'(wiper_ofs);
  assign below_ofs = (div_quo < ofs_ext);

  assign q_push  = (st_r == ST_DONE) && !q_stat.full;
  assign in_full = !((st_r == ST_IDLE) || q_push);
  assign accept  = in_push && !in_full;
  assign q_code  = code_r;

  // Divider launch: resistance for a gain above unity, then steps if not below the offset.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = gain_num;
    div_dvs   = in_value - GAIN_UNITY;
    if (accept && (in_func == FUNC_GAIN) && (in_value > GAIN_UNITY)) begin
      div_start = 1'b1;
    end else if ((st_r == ST_DIV_R) && div_st.done && !below_ofs) begin
      div_start = 1'b1;
      div_dvd   = div_quo - ofs_ext;
      div_dvs   = VAL_W'(ohms_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            if (in_func == FUNC_RAW) begin
              code_r <= in_value[CODE_W-1:0];
              st_r   <= ST_DONE;
            end else if (in_value <= GAIN_UNITY) begin
              code_r <= CODE_MAX;
              st_r   <= ST_DONE;
            end else begin
              st_r <= ST_DIV_R;
            end
          end else if (q_push) begin
            st_r <= ST_IDLE;
          end
        end
        ST_DIV_R: begin
          if (div_st.done) begin
            if (below_ofs) begin
              code_r <= CODE_MIN;
              st_r   <= ST_DONE;
            end else begin
              st_r <= ST_DIV_C;
            end
          end
        end
        ST_DIV_C: begin
          if (div_st.done) begin
            if (div_quo > NUM_W'(CODE_MAX)) begin
              code_r <= CODE_MAX;
            end else if (div_quo == '0) begin
              code_r <= CODE_MIN;
            end else begin
              code_r <= div_quo[CODE_W-1:0];
            end
            st_r <= ST_DONE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  gtd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_st)
  );

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || div_st.done) |-> (st_r == ST_DIV_R || st_r == ST_DIV_C))
    else $error("divider active outside a divide state");

  a_no_push_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !q_push)
    else $error("code pushed while divider is busy");

endmodule

// ----- hw/rtl/gtd_fifo.sv -----
`timescale 1ns / 1ps

module gtd_fifo
  import gtd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [CODE_W-1:0] din,
  input  logic              pop,
  output logic [CODE_W-1:0] dout,
  output q_stat_t           stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("push into a full queue");

endmodule

// ----- hw/rtl/gtd_back.sv -----
`timescale 1ns / 1ps

module gtd_back
  import gtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  logic [CODE_W-1:0] q_code,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CODE_W-1:0] out_wiper_code,
  output logic              out_serial_bit,
  output logic [IDX_W-1:0]  out_bit_index,
  output logic              out_last
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BITS - 1);

  logic                  act_r, ovld_r;
  logic [CODE_W-1:0]     cur_code_r;
  logic [IDX_W-1:0]      idx_r;
  logic [CODE_W-1:0]     oc_r;
  logic                  obit_r, olast_r;
  logic [IDX_W-1:0]      oidx_r;
  logic [FRAME_BITS-1:0] frame;
  logic                  load_out;

  assign frame    = {CMD_WRITE, cur_code_r};
  assign load_out = act_r && (!ovld_r || out_pop);
  assign q_pop    = !q_stat.empty && (!act_r || (load_out && idx_r == IDX_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (load_out) begin
        ovld_r <= 1'b1;
      end else if (out_pop) begin
        ovld_r <= 1'b0;
      end
      if (q_pop) begin
        act_r <= 1'b1;
      end else if (load_out && idx_r == IDX_LAST) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_code_r <= q_code;
      idx_r      <= '0;
    end else if (load_out) begin
      idx_r <= idx_r + 1'b1;
    end
    if (load_out) begin
      oc_r    <= cur_code_r;
      obit_r  <= frame[IDX_LAST - idx_r];
      oidx_r  <= idx_r;
      olast_r <= (idx_r == IDX_LAST);
    end
  end

  assign out_empty      = !ovld_r;
  assign out_wiper_code = oc_r;
  assign out_serial_bit = obit_r;
  assign out_bit_index  = oidx_r;
  assign out_last       = olast_r;

  a_code_holds_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && out_pop && !olast_r) |=> (oc_r == $past(oc_r)))
    else $error("wiper code changed inside a frame");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && out_pop && !olast_r) |=>
      (!ovld_r || oidx_r == IDX_W'($past(oidx_r) + 1'b1)))
    else $error("bit index skipped inside a frame");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> (olast_r == (oidx_r == IDX_LAST)))
    else $error("last flag not on the final bit");

endmodule

// ----- hw/rtl/gain_to_digipot_spi_writer_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in_       input      in_push / in_full           in_func, in_value
// out_      output     out_empty / out_pop         out_wiper_code, out_serial_bit,
//                                                  out_bit_index, out_last
// cfg_      input      cfg_we (no wait)            cfg_index, cfg_wdata
//
// A raw request or a gain of 1.0 or less is registered as its code, then sent to the code queue.
// Any other gain request runs the restoring divider for the resistance and, unless that falls
// below the offset, a second time for the step count. The front end takes no new request
// while the divider runs.
// The back end emits 16 bits a word, one per cycle while out_pop is high and codes are queued.
// Reset (rst_n low, synchronous) empties both sides and loads the default register values.
// Either side may stall on its own; the code queue and the output register decouple them.

module gain_to_digipot_spi_writer_top
  import gtd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [VAL_W-1:0]      in_value,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [CODE_W-1:0]     out_wiper_code,
  output logic                  out_serial_bit,
  output logic [IDX_W-1:0]      out_bit_index,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [NUM_W-1:0]  gain_num_r;
  logic [OFS_W-1:0]  wiper_ofs_r;
  logic [STEP_W-1:0] ohms_step_r;

  q_stat_t           q_stat;
  logic              q_push, q_pop;
  logic [CODE_W-1:0] q_din, q_dout;

  // Configuration registers. A write to an unused index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_num_r  <= GAIN_NUM_RST;
      wiper_ofs_r <= WIPER_OFS_RST;
      ohms_step_r <= OHMS_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_NUM:  gain_num_r  <= cfg_wdata[NUM_W-1:0];
        CFG_WIPER_OFS: wiper_ofs_r <= cfg_wdata[OFS_W-1:0];
        CFG_OHMS_STEP: ohms_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: takes requests and works out the wiper code.
  gtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_value  (in_value),
    .gain_num  (gain_num_r),
    .wiper_ofs (wiper_ofs_r),
    .ohms_step (ohms_step_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_code    (q_din)
  );

  // Short queue of finished codes between the two halves.
  gtd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // Back end: turns each code into a 16-bit write frame, MSB first.
  gtd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_code         (q_dout),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_wiper_code (out_wiper_code),
    .out_serial_bit (out_serial_bit),
    .out_bit_index  (out_bit_index),
    .out_last       (out_last)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the gain-to-wiper-code SPI frame writer.
// A queue of requests is filled by the main initial block and fed to the block
// by a clocked driver. A clocked monitor predicts the 16-bit frame of every
// request taken and checks the frame bits as they are popped.
module tb_top;
  import gtd_pkg::*;

  // Index 3 is not decoded by the block. Writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PERCENT  = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 10;
  localparam int WORDS_PER_PHASE = 25;

  typedef struct packed {
    logic             func;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              sbit;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } frame_bit_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_func;
  logic [VAL_W-1:0]      in_value;
  logic                  out_empty;
  logic                  out_pop;
  logic [CODE_W-1:0]     out_wiper_code;
  logic                  out_serial_bit;
  logic [IDX_W-1:0]      out_bit_index;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Requests not yet taken by the block, and frame bits still owed by it.
  request_t   requests_waiting[$];
  frame_bit_t frame_bits_due[$];

  // Our own copy of the three registers, updated as they are written.
  int unsigned gain_num;
  int unsigned wiper_ofs;
  int unsigned step_ohms;

  int  mismatches     = 0;
  int  words_taken    = 0;
  int  bits_checked   = 0;
  int  settings_count = 0;
  int  cycle_count    = 0;
  int  hold_left      = 0;
  bit  word_taken     = 1'b0;
  bit  calm           = 1'b0;
  bit  hold_request   = 1'b0;

  gain_to_digipot_spi_writer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_wiper_code (out_wiper_code),
    .out_serial_bit (out_serial_bit),
    .out_bit_index  (out_bit_index),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Wiper code for one request, given the current register values. A gain of
  // 1.0 or less asks for the widest setting. Otherwise the feedback resistance
  // is mapped onto wiper steps above the configured offset, clamped to 1..255. With
  // a step size of zero the divider saturates, so the code is the maximum.
  function automatic logic [CODE_W-1:0] predict_wiper_code(logic func,
                                                           logic [VAL_W-1:0] value);
    int unsigned ohms;
    int unsigned steps;
    if (func == FUNC_RAW) return value[CODE_W-1:0];
    if (value <= GAIN_UNITY) return CODE_MAX;
    ohms = gain_num / (int'(value) - int'(GAIN_UNITY));
    if (ohms < wiper_ofs) return CODE_MIN;
    if (step_ohms == 0) return CODE_MAX;
    steps = (ohms - wiper_ofs) / step_ohms;
    if (steps < int'(CODE_MIN)) return CODE_MIN;
    if (steps > int'(CODE_MAX)) return CODE_MAX;
    return steps[CODE_W-1:0];
  endfunction

  // The frame is the write command byte followed by the code, MSB first.
  task automatic queue_frame(logic [CODE_W-1:0] code);
    logic [FRAME_BITS-1:0] frame;
    frame_bit_t fb;
    frame = {CMD_WRITE, code};
    for (int i = 0; i < FRAME_BITS; i++) begin
      fb.code = code;
      fb.sbit = frame[FRAME_BITS-1-i];
      fb.idx  = IDX_W'(i);
      fb.last = (i == FRAME_BITS - 1);
      frame_bits_due.push_back(fb);
    end
  endtask

  // Driver. A word stays on the bus until the block takes it; after that the
  // next decision is made: either present the next request or idle for a cycle.
  // While idle the payload carries junk so the block cannot rely on it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && !word_taken)) begin
      word_taken = 1'b0;
      if (requests_waiting.size() > 0 &&
          (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_push  <= 1'b1;
        in_func  <= requests_waiting[0].func;
        in_value <= requests_waiting[0].value;
      end else begin
        in_push  <= 1'b0;
        in_func  <= 1'($urandom);
        in_value <= VAL_W'($urandom);
      end
    end
  end

  // Receiver. It pops at random, or always while calm, except during the long
  // hold-off, which it counts down on its own while the sender keeps pushing into a full block.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_pop     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Monitor. Every word taken on the input side is turned into its 16
  // expected frame bits; every word popped on the output side is checked
  // field by field against the oldest expected bit.
  always @(posedge clk) begin
    frame_bit_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        void'(requests_waiting.pop_front());
        queue_frame(predict_wiper_code(in_func, in_value));
        words_taken++;
        word_taken = 1'b1;
      end
      if (out_pop && !out_empty) begin
        if (frame_bits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected word: code %0d bit %0d index %0d last %0d",
                     $realtime, out_wiper_code, out_serial_bit, out_bit_index,
                     out_last);
        end else begin
          want = frame_bits_due.pop_front();
          bits_checked++;
          if (out_wiper_code !== want.code || out_serial_bit !== want.sbit ||
              out_bit_index !== want.idx || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] mismatch: expected code %0d bit %0d index %0d last %0d,",
                        " got code %0d bit %0d index %0d last %0d"},
                       $realtime, want.code, want.sbit, want.idx, want.last,
                       out_wiper_code, out_serial_bit, out_bit_index, out_last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL gain_to_digipot_spi_writer_top");
      $finish;
    end
  end

  task automatic add_request(logic func, logic [VAL_W-1:0] value);
    request_t req;
    req.func  = func;
    req.value = value;
    requests_waiting.push_back(req);
  endtask

  // Random request. Raw codes and small gains dominate, since small gains are
  // the ones that land inside the wiper range; full-width gains cover the top bits.
  task automatic add_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)
      add_request(FUNC_RAW, VAL_W'($urandom_range(65535)));
    else if (pick < 80)
      add_request(FUNC_GAIN, VAL_W'($urandom_range(2047)));
    else
      add_request(FUNC_GAIN, VAL_W'($urandom_range(65535)));
  endtask

  // One register write. The enable stays high across back-to-back writes and
  // is lowered by apply_settings once the last one is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GAIN_NUM:  gain_num  = data[NUM_W-1:0];
      CFG_WIPER_OFS: wiper_ofs = data[OFS_W-1:0];
      CFG_OHMS_STEP: step_ohms = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned num, int unsigned ofs, int unsigned step);
    write_reg(CFG_GAIN_NUM, CFG_DATA_W'(num));
    write_reg(CFG_WIPER_OFS, CFG_DATA_W'(ofs));
    write_reg(CFG_OHMS_STEP, CFG_DATA_W'(step));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
    @(posedge clk);
  endtask

  // Registers may only change once every owed frame bit has arrived. A short
  // pause then covers anything still in flight inside the block.
  task automatic wait_idle();
    @(posedge clk);
    while (requests_waiting.size() > 0 || frame_bits_due.size() > 0 || in_push)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_func   = 1'b0;
    in_value  = '0;
    out_pop   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gain_num  = GAIN_NUM_RST;
    wiper_ofs = WIPER_OFS_RST;
    step_ohms = OHMS_STEP_RST;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings. Raw mode: the edges of the code
    // and junk in the upper byte. Gain mode: zero, exactly unity, just above
    // unity (clamps high), the largest gains (resistance below the offset),
    // and gains around the points where the code reaches its low clamp.
    add_request(FUNC_RAW, 16'h0000);
    add_request(FUNC_RAW, 16'h00FF);
    add_request(FUNC_RAW, 16'hFFFF);
    add_request(FUNC_RAW, 16'hFF00);
    add_request(FUNC_RAW, 16'h5AA5);
    add_request(FUNC_RAW, 16'hA55A);
    add_request(FUNC_GAIN, 16'd0);
    add_request(FUNC_GAIN, 16'd10);
    add_request(FUNC_GAIN, 16'd11);
    add_request(FUNC_GAIN, 16'd12);
    add_request(FUNC_GAIN, 16'hFFFF);
    add_request(FUNC_GAIN, 16'h8000);
    add_request(FUNC_GAIN, 16'd100);
    add_request(FUNC_GAIN, 16'd150);
    add_request(FUNC_GAIN, 16'd200);
    add_request(FUNC_GAIN, 16'd400);
    add_request(FUNC_GAIN, 16'd1000);
    add_request(FUNC_GAIN, 16'd1300);
    add_request(FUNC_GAIN, 16'd9509);
    add_request(FUNC_GAIN, 16'd9600);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(20'hFFFFF, 1023, 4095);       // all registers at maximum
        1: apply_settings(1, 0, 1);                     // smallest legal values
        2: apply_settings(GAIN_NUM_RST, WIPER_OFS_RST, 0); // divider saturates
        3: apply_settings(0, WIPER_OFS_RST, OHMS_STEP_RST); // zero numerator, below offset
        4: apply_settings(0, 0, OHMS_STEP_RST);         // zero numerator, low clamp
        5: apply_settings(GAIN_NUM_RST, WIPER_OFS_RST, OHMS_STEP_RST);
        default: apply_settings($urandom_range(20'hFFFFF, 1), $urandom_range(1023),
                                $urandom_range(4095, 1));
      endcase
      // Phase 1 starves the output for a long stretch so the block backs up;
      // phase 5 runs with neither side idling.
      hold_request = (phase == 1);
      calm         = (phase == 5);
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        add_random_request();
      wait_idle();
      calm = 1'b0;
    end

    // Let any stray trailing words show up before the verdict.
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests and %0d frame bits over %0d register settings,",
             words_taken, bits_checked, settings_count + 1);
    $display("including register extremes, zero step size, zero numerator and a long output stall.");
    if (mismatches == 0 && frame_bits_due.size() == 0) begin
      $display("PASS gain_to_digipot_spi_writer_top");
    end else begin
      $display("%0d mismatches, %0d frame bits never seen", mismatches,
               frame_bits_due.size());
      $display("FAIL gain_to_digipot_spi_writer_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gtd_pkg.sv
hw/rtl/gtd_div.sv
hw/rtl/gtd_front.sv
hw/rtl/gtd_fifo.sv
hw/rtl/gtd_back.sv
hw/rtl/gain_to_digipot_spi_writer_top.sv
tb/tb_top.sv
